[design/blc_pkg.sv]
package blc_pkg;

	// List size and the widths that follow from it.
	localparam int CAPACITY = 32;
	localparam int CIDX_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	// Fixed field widths of the item ports.
	localparam int ACT_W   = 2;
	localparam int VAL_W   = 32;
	localparam int POS_W   = 10;
	localparam int PLACE_W = 6;

	// Action codes carried by an input item.
	localparam logic [ACT_W-1:0] ACT_FRONT  = 2'd0;
	localparam logic [ACT_W-1:0] ACT_BACK   = 2'd1;
	localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd2;

	// Operation broadcast to every cell of the row.
	typedef enum logic [2:0] {
		OP_HOLD,
		OP_FRONT,
		OP_BACK,
		OP_REMOVE,
		OP_ROTATE
	} cell_op_t;

	typedef struct packed {
		cell_op_t                  op;
		logic signed [VAL_W-1:0]   value;
		logic        [POS_W-1:0]   pos;
		logic        [CNT_W-1:0]   count;
	} cell_ctl_t;

	typedef enum logic {
		ST_IDLE,
		ST_DUMP
	} state_t;

endpackage

[design/blc_cell.sv]
module blc_cell import blc_pkg::*; (
	input  logic                     clk,
	input  cell_ctl_t                ctl,
	input  logic [CIDX_W-1:0]        idx,
	input  logic signed [VAL_W-1:0]  prev_val,
	input  logic signed [VAL_W-1:0]  next_val,
	input  logic signed [VAL_W-1:0]  head_val,
	output logic signed [VAL_W-1:0]  val_q
);

	logic [CNT_W-1:0]        idx_c;
	logic [POS_W-1:0]        idx_p;
	logic signed [VAL_W-1:0] val_d;

	assign idx_c = CNT_W'(idx);
	assign idx_p = POS_W'(idx);

	// Choose what this cell holds next, from the broadcast operation and its own place.
	always_comb begin
		val_d = val_q;
		unique case (ctl.op)
			OP_HOLD: val_d = val_q;
			OP_FRONT: val_d = prev_val;
			OP_BACK: begin
				if (idx_c == ctl.count) val_d = ctl.value;
			end
			OP_REMOVE: begin
				if (idx_p >= ctl.pos) val_d = next_val;
			end
			OP_ROTATE: begin
				// The last live cell takes the head so the list comes back in place.
				if (CNT_W'(idx_c + 1'b1) == ctl.count) val_d = head_val;
				else val_d = next_val;
			end
			default: val_d = val_q;
		endcase
	end

	always_ff @(posedge clk) begin
		val_q <= val_d;
	end

endmodule

[design/bounded_list_head_tail_delete_unit.sv]
// Bounded ordered list of up to CAPACITY signed values, held in a row of cells that each
// hold one element and pass values to their neighbours. An input item inserts at the
// front, inserts at the back or removes at a position; the edit is made in the whole
// row at once. The block then dumps the whole list from the front, one item per cycle
// while out_stall is low, by rotating the row through cell 0; the final item carries
// is_last, and an empty list gives a single item with list_empty set. The block takes
// no new item during a dump: input stall stays high until the last result item has
// been taken.
module bounded_list_head_tail_delete_unit import blc_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [ACT_W-1:0]          action,
	input  logic signed [VAL_W-1:0]   value,
	input  logic [POS_W-1:0]          position,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic signed [VAL_W-1:0]   element,
	output logic [PLACE_W-1:0]        place,
	output logic                      is_last,
	output logic                      list_empty,
	output logic                      overflow
);

	state_t              state_q, state_d;
	logic [CNT_W-1:0]    count_q;
	logic [CIDX_W-1:0]   place_q;
	logic                ovf_q;
	cell_ctl_t           ctl;
	logic                in_acc, out_acc, full, rem_ok, empty;
	logic signed [VAL_W-1:0] vals [CAPACITY];

	assign in_acc  = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;
	assign full    = (count_q == CNT_W'(CAPACITY));
	assign rem_ok  = (position < POS_W'(count_q));
	assign empty   = (count_q == '0);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_acc) state_d = ST_DUMP;
			ST_DUMP: if (out_acc && is_last) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Handshake outputs and the operation sent along the row.
	always_comb begin
		in_stall  = (state_q != ST_IDLE);
		out_valid = (state_q == ST_DUMP);
		ctl.op    = OP_HOLD;
		ctl.value = value;
		ctl.pos   = position;
		ctl.count = count_q;
		if (in_acc) begin
			case (action)
				ACT_FRONT: ctl.op = full ? OP_HOLD : OP_FRONT;
				ACT_BACK: ctl.op = full ? OP_HOLD : OP_BACK;
				ACT_REMOVE: ctl.op = rem_ok ? OP_REMOVE : OP_HOLD;
				default: ctl.op = OP_HOLD;
			endcase
		end else if (out_acc && !empty) begin
			ctl.op = OP_ROTATE;
		end
	end

	// Result item fields come from the head cell, the dump counter and the element count.
	assign list_empty = empty;
	assign element    = empty ? '0 : vals[0];
	assign place      = PLACE_W'(place_q);
	assign is_last    = empty || (CNT_W'(CNT_W'(place_q) + 1'b1) == count_q);
	assign overflow   = ovf_q;

	// Control registers: state, element count, dump position and overflow flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			place_q <= '0;
			ovf_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_acc) begin
				place_q <= '0;
				ovf_q   <= (action == ACT_FRONT || action == ACT_BACK) && full;
				if ((action == ACT_FRONT || action == ACT_BACK) && !full) begin
					count_q <= CNT_W'(count_q + 1'b1);
				end else if (action == ACT_REMOVE && rem_ok) begin
					count_q <= CNT_W'(count_q - 1'b1);
				end
			end else if (out_acc) begin
				place_q <= CIDX_W'(place_q + 1'b1);
			end
		end
	end

	// The row of cells; cell 0 takes the new value on a front insert.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [VAL_W-1:0] prev_v, next_v;
		if (i == 0) begin : g_first
			assign prev_v = value;
		end else begin : g_mid
			assign prev_v = vals[i-1];
		end
		if (i == CAPACITY - 1) begin : g_end
			assign next_v = vals[i];
		end else begin : g_inner
			assign next_v = vals[i+1];
		end
		blc_cell u_cell (
			.clk      (clk),
			.ctl      (ctl),
			.idx      (CIDX_W'(i)),
			.prev_val (prev_v),
			.next_val (next_v),
			.head_val (vals[0]),
			.val_q    (vals[i])
		);
	end

endmodule

[design/blc_checker.sv]
module blc_checker import blc_pkg::*; (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     in_valid,
	input logic                     in_stall,
	input logic [ACT_W-1:0]         action,
	input logic signed [VAL_W-1:0]  value,
	input logic [POS_W-1:0]         position,
	input logic                     out_valid,
	input logic                     out_stall,
	input logic signed [VAL_W-1:0]  element,
	input logic [PLACE_W-1:0]       place,
	input logic                     is_last,
	input logic                     list_empty,
	input logic                     overflow
);

	// A stalled result item keeps its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(element) && $stable(place)
			&& $stable(is_last) && $stable(overflow))
		else $error("result item changed while stalled");

	// No new item is taken while a dump is under way.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input taken during a dump");

	// Every item starts its dump at the front of the list.
	a_dump_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> out_valid && place == '0)
		else $error("dump did not start at place zero");

	// Within a dump the places run up by one, and list_empty never shows after an item that is not last.
	a_dump_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !is_last |=> out_valid && !list_empty
			&& place == PLACE_W'($past(place) + 1'b1))
		else $error("dump place sequence broken");

endmodule

bind bounded_list_head_tail_delete_unit blc_checker u_blc_checker (.*);
